[rtl/ngfc_pkg.sv]
// Shared constants, table write beat type and helper functions for the n-gram counter.
// Used by ngfc_table, ngram_frequency_counter, ngfc_checker and the testbench; no dependencies.
package ngfc_pkg;

    localparam int MAX_GRAM      = 8;
    localparam int GRAM_W        = 8 * MAX_GRAM;
    localparam int LEN_W         = 4;
    localparam int FILL_W        = 4;
    localparam int TABLE_ENTRIES = 1024;
    localparam int ADDR_W        = $clog2(TABLE_ENTRIES);
    localparam int USED_W        = ADDR_W + 1;
    localparam int COUNT_BITS    = 32;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX  = '1;
    localparam logic [COUNT_BITS-1:0] COUNT_ONE  = COUNT_BITS'(1);
    localparam logic [USED_W-1:0]     USED_LIMIT = USED_W'(TABLE_ENTRIES);

    typedef struct packed {
        logic                  key_we;
        logic                  count_we;
        logic [ADDR_W-1:0]     addr;
        logic                  valid;
        logic [GRAM_W-1:0]     key;
        logic [COUNT_BITS-1:0] count;
    } t_tbl_wr;

    function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] l;
        l = len;
        if (l == '0) begin
            l = LEN_W'(1);
        end else if (l > LEN_W'(MAX_GRAM)) begin
            l = LEN_W'(MAX_GRAM);
        end
        return l;
    endfunction

    function automatic logic [GRAM_W-1:0] gram_mask(input logic [LEN_W-1:0] len);
        logic [GRAM_W-1:0] m;
        m = '0;
        for (int b = 0; b < MAX_GRAM; b++) begin
            if (LEN_W'(b) < len) begin
                m[8*b +: 8] = 8'hff;
            end
        end
        return m;
    endfunction

    function automatic logic [ADDR_W-1:0] gram_hash(input logic [GRAM_W-1:0] g);
        logic [ADDR_W-1:0] h;
        h = '0;
        for (int i = 0; i < GRAM_W; i++) begin
            h[i % ADDR_W] = h[i % ADDR_W] ^ g[i];
        end
        return h;
    endfunction

endpackage

[rtl/ngfc_table.sv]
// Count table: key/valid memory and count memory, one write port each, shared read address.
// Read data is registered. Depends on ngfc_pkg.
module ngfc_table
    import ngfc_pkg::*;
(
    input  logic                  i_clk,
    input  logic [ADDR_W-1:0]     i_rd_addr,
    input  t_tbl_wr               i_wr,
    output logic                  o_rd_valid,
    output logic [GRAM_W-1:0]     o_rd_key,
    output logic [COUNT_BITS-1:0] o_rd_count
);

    logic [GRAM_W:0]       r_key_mem   [TABLE_ENTRIES];
    logic [COUNT_BITS-1:0] r_count_mem [TABLE_ENTRIES];
    logic [GRAM_W:0]       r_rd_key;
    logic [COUNT_BITS-1:0] r_rd_count;

    always_ff @(posedge i_clk) begin
        if (i_wr.key_we) begin
            r_key_mem[i_wr.addr] <= {i_wr.valid, i_wr.key};
        end
        r_rd_key <= r_key_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.count_we) begin
            r_count_mem[i_wr.addr] <= i_wr.count;
        end
        r_rd_count <= r_count_mem[i_rd_addr];
    end

    assign o_rd_valid = r_rd_key[GRAM_W];
    assign o_rd_key   = r_rd_key[GRAM_W-1:0];
    assign o_rd_count = r_rd_count;

endmodule

[rtl/ngram_frequency_counter.sv]
// N-gram frequency counter: sliding byte window, hashed linear-probe count table.
// Depends on ngfc_pkg and ngfc_table.
// Each probe passes S_WAIT then S_CMP (1..1024 probes); the result strobe is registered.
// A new byte is taken only in S_IDLE; a byte that gives no gram leaves the block idle.
// Reset: synchronous, active low; then a clearing pass over all 1024 entries with busy high.
// The receiver cannot stall: each result is on the ports for one cycle with o_valid.
module ngram_frequency_counter
    import ngfc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [7:0]            i_char_in,
    input  logic                  i_cfg_we,
    input  logic [LEN_W-1:0]      i_cfg_wdata,
    output logic                  o_valid,
    output logic [GRAM_W-1:0]     o_gram,
    output logic [COUNT_BITS-1:0] o_gram_count,
    output logic                  o_table_full
);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_WAIT  = 4'b0100,
        S_CMP   = 4'b1000
    } t_state;

    t_state                r_state, n_state;
    logic [LEN_W-1:0]      r_len;
    logic [GRAM_W-1:0]     r_window, n_window;
    logic [FILL_W-1:0]     r_fill, n_fill;
    logic [GRAM_W-1:0]     r_gram, n_gram;
    logic [ADDR_W-1:0]     r_addr, n_addr;
    logic [ADDR_W-1:0]     r_probes, n_probes;
    logic [USED_W-1:0]     r_used, n_used;
    logic                  r_valid, n_valid;
    logic [COUNT_BITS-1:0] r_count, n_count;
    logic                  r_full, n_full;
    logic [GRAM_W-1:0]     r_out_gram, n_out_gram;

    t_tbl_wr               tbl_wr;
    logic                  rd_valid;
    logic [GRAM_W-1:0]     rd_key;
    logic [COUNT_BITS-1:0] rd_count;
    logic [LEN_W-1:0]      len;
    logic [GRAM_W-1:0]     shifted;

    ngfc_table u_table (
        .i_clk      (i_clk),
        .i_rd_addr  (r_addr),
        .i_wr       (tbl_wr),
        .o_rd_valid (rd_valid),
        .o_rd_key   (rd_key),
        .o_rd_count (rd_count)
    );

    assign len     = eff_len(r_len);
    assign shifted = {r_window[GRAM_W-9:0], i_char_in};

    always_comb begin
        n_state    = r_state;
        n_window   = r_window;
        n_fill     = r_fill;
        n_gram     = r_gram;
        n_addr     = r_addr;
        n_probes   = r_probes;
        n_used     = r_used;
        n_valid    = 1'b0;
        n_count    = r_count;
        n_full     = r_full;
        n_out_gram = r_out_gram;
        tbl_wr     = '{key_we: 1'b0, count_we: 1'b0, addr: r_addr, valid: 1'b0,
                       key: r_gram, count: COUNT_ONE};
        unique case (r_state)
            S_CLEAR: begin
                tbl_wr.key_we = 1'b1;
                n_addr        = r_addr + ADDR_W'(1);
                if (r_addr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_window = shifted;
                    if (r_fill < FILL_W'(MAX_GRAM)) begin
                        n_fill = r_fill + FILL_W'(1);
                    end
                    if (FILL_W'(n_fill) >= FILL_W'(len)) begin
                        n_gram   = shifted & gram_mask(len);
                        n_addr   = gram_hash(shifted & gram_mask(len));
                        n_probes = '0;
                        n_state  = S_WAIT;
                    end
                end
            end
            S_WAIT: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                n_out_gram = r_gram;
                priority if (rd_valid && rd_key == r_gram) begin
                    n_count         = (rd_count == COUNT_MAX) ? rd_count
                                                              : rd_count + COUNT_ONE;
                    tbl_wr.count_we = 1'b1;
                    tbl_wr.count    = n_count;
                    n_full          = 1'b0;
                    n_valid         = 1'b1;
                    n_state         = S_IDLE;
                end else if (!rd_valid) begin
                    tbl_wr.key_we   = 1'b1;
                    tbl_wr.count_we = 1'b1;
                    tbl_wr.valid    = 1'b1;
                    n_used          = r_used + USED_W'(1);
                    n_count         = COUNT_ONE;
                    n_full          = 1'b0;
                    n_valid         = 1'b1;
                    n_state         = S_IDLE;
                end else if (r_probes == '1) begin
                    n_count = '0;
                    n_full  = 1'b1;
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_addr   = r_addr + ADDR_W'(1);
                    n_probes = r_probes + ADDR_W'(1);
                    n_state  = S_WAIT;
                end
            end
            default: begin
                n_state = S_CLEAR;
                n_addr  = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_len    <= LEN_W'(2);
            r_window <= '0;
            r_fill   <= '0;
            r_addr   <= '0;
            r_probes <= '0;
            r_used   <= '0;
            r_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            if (i_cfg_we) begin
                r_len <= i_cfg_wdata;
            end
            r_window <= n_window;
            r_fill   <= n_fill;
            r_addr   <= n_addr;
            r_probes <= n_probes;
            r_used   <= n_used;
            r_valid  <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_gram     <= n_gram;
        r_count    <= n_count;
        r_full     <= n_full;
        r_out_gram <= n_out_gram;
    end

    assign busy         = (r_state != S_IDLE);
    assign o_valid      = r_valid;
    assign o_gram       = r_out_gram;
    assign o_gram_count = r_count;
    assign o_table_full = r_full;

    a_strobe_after_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == S_CMP))
        else $error("result strobe without a compare cycle");

    a_full_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_table_full) |-> (o_gram_count == '0))
        else $error("table full result carries a count");

    a_stored_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_table_full) |-> (o_gram_count != '0))
        else $error("stored gram reports zero count");

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= USED_LIMIT)
        else $error("entry count exceeds table size");

    a_full_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_table_full) |-> (r_used == USED_LIMIT))
        else $error("table full flagged with free entries");

endmodule

[sim/ngfc_checker.sv]
// Checker for the n-gram frequency counter: tracks byte and config beats,
// predicts each gram/count result, and compares it with the block's output.
// Depends on ngfc_pkg for the widths and the table size.
module ngfc_checker
    import ngfc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  i_busy,
    input  logic [7:0]            i_char_in,
    input  logic                  i_cfg_we,
    input  logic [LEN_W-1:0]      i_cfg_wdata,
    input  logic                  i_valid,
    input  logic [GRAM_W-1:0]     i_gram,
    input  logic [COUNT_BITS-1:0] i_gram_count,
    input  logic                  i_table_full,
    output int                    o_fails,
    output int                    o_pending,
    output int                    o_grams_stored,
    output int                    o_results,
    output int                    o_full_hits
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [GRAM_W-1:0]     gram;
        logic [COUNT_BITS-1:0] count;
        logic                  full;
    } t_gram_result;

    t_gram_result          expected_q[$];
    logic [COUNT_BITS-1:0] gram_tally[logic [GRAM_W-1:0]];
    logic [LEN_W-1:0]      len_reg;
    logic [GRAM_W-1:0]     shift_win;
    int                    win_fill;

    task automatic report_mismatch(input string what, input logic [GRAM_W-1:0] got,
                                   input logic [GRAM_W-1:0] want);
        $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
        o_fails++;
    endtask

    task automatic predict_byte(input logic [7:0] b);
        int           len;
        logic [GRAM_W-1:0] g;
        t_gram_result r;
        len = (len_reg == 0) ? 1 : (len_reg > MAX_GRAM) ? MAX_GRAM : int'(len_reg);
        shift_win = {shift_win[GRAM_W-9:0], b};
        if (win_fill < MAX_GRAM) begin
            win_fill++;
        end
        if (win_fill >= len) begin
            g = (len >= 8) ? shift_win : shift_win & ((64'd1 << (8 * len)) - 64'd1);
            r.gram = g;
            r.full = 1'b0;
            if (gram_tally.exists(g)) begin
                if (gram_tally[g] != COUNT_MAX) begin
                    gram_tally[g]++;
                end
                r.count = gram_tally[g];
            end else if (o_grams_stored >= TABLE_ENTRIES) begin
                r.count = '0;
                r.full  = 1'b1;
            end else begin
                gram_tally[g] = COUNT_ONE;
                o_grams_stored++;
                r.count = COUNT_ONE;
            end
            expected_q = {expected_q, r};
        end
    endtask

    initial begin
        o_fails = 0;
        o_pending = 0;
        o_grams_stored = 0;
        o_results = 0;
        o_full_hits = 0;
    end

    always @(posedge i_clk) begin
        t_gram_result e;
        if (!i_rst_n) begin
            expected_q.delete();
            gram_tally.delete();
            len_reg = LEN_W'(2);
            shift_win = '0;
            win_fill = 0;
            o_grams_stored = 0;
        end else begin
            if (i_cfg_we) begin
                len_reg = i_cfg_wdata;
            end
            if (i_start && !i_busy) begin
                predict_byte(i_char_in);
            end
            if (i_valid) begin
                o_results++;
                if (i_table_full) begin
                    o_full_hits++;
                end
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected beat, gram", i_gram, '0);
                end else begin
                    e = expected_q.pop_front();
                    if (i_gram !== e.gram) begin
                        report_mismatch("gram", i_gram, e.gram);
                    end
                    if (i_gram_count !== e.count) begin
                        report_mismatch("gram_count", 64'(i_gram_count), 64'(e.count));
                    end
                    if (i_table_full !== e.full) begin
                        report_mismatch("table_full", 64'(i_table_full), 64'(e.full));
                    end
                end
            end
        end
        o_pending = expected_q.size();
    end

endmodule

[sim/tb_ngram_frequency_counter.sv]
// Testbench top for ngram_frequency_counter: clock, reset, byte and config stimulus.
// Depends on ngfc_pkg, the block and ngfc_checker, which predicts and compares.
module tb_ngram_frequency_counter;
    import ngfc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic [7:0]            char_in;
    logic                  cfg_we;
    logic [LEN_W-1:0]      cfg_wdata;
    logic                  valid;
    logic [GRAM_W-1:0]     gram;
    logic [COUNT_BITS-1:0] gram_count;
    logic                  table_full;
    int                    fails;
    int                    pending;
    int                    grams_stored;
    int                    results;
    int                    full_hits;
    int                    bytes_sent;
    int                    burst_left;
    logic [7:0]            alphabet[4];

    ngram_frequency_counter dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .start        (start),
        .busy         (busy),
        .i_char_in    (char_in),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .o_valid      (valid),
        .o_gram       (gram),
        .o_gram_count (gram_count),
        .o_table_full (table_full)
    );

    ngfc_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_char_in      (char_in),
        .i_cfg_we       (cfg_we),
        .i_cfg_wdata    (cfg_wdata),
        .i_valid        (valid),
        .i_gram         (gram),
        .i_gram_count   (gram_count),
        .i_table_full   (table_full),
        .o_fails        (fails),
        .o_pending      (pending),
        .o_grams_stored (grams_stored),
        .o_results      (results),
        .o_full_hits    (full_hits)
    );

    always begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left > 0) begin
            gap = 0;
            burst_left--;
        end else begin
            gap = $urandom_range(0, 18);
            if ($urandom_range(0, 15) == 0) begin
                burst_left = $urandom_range(10, 40);
            end
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        if (busy) begin
            start <= 1'b0;
            while (busy) begin
                @(negedge clk);
            end
        end
        start   <= 1'b1;
        char_in <= b;
        @(negedge clk);
        bytes_sent++;
    endtask

    task automatic write_length(input logic [LEN_W-1:0] len);
        start <= 1'b0;
        @(negedge clk);
        while (pending != 0 || busy) begin
            @(negedge clk);
        end
        repeat (8) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= len;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [7:0] pick_byte();
        return ($urandom_range(0, 9) < 8) ? alphabet[$urandom_range(0, 3)] : 8'($urandom);
    endfunction

    initial begin
        #200ms;
        $display("[ngram_frequency_counter] ERROR");
        $finish;
    end

    initial begin
        int guard;
        start      = 1'b0;
        char_in    = '0;
        cfg_we     = 1'b0;
        cfg_wdata  = '0;
        rst_n      = 1'b0;
        bytes_sent = 0;
        burst_left = 0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        while (busy) begin
            @(negedge clk);
        end

        // reset length, extremes, lengths 0 and above 8, shared packed values
        foreach (alphabet[i]) alphabet[i] = (i % 2) ? 8'hff : 8'h00;
        send_byte(8'h00); send_byte(8'h00); send_byte(8'hff); send_byte(8'hff);
        send_byte(8'h00); send_byte(8'hff);
        write_length(LEN_W'(0));
        send_byte(8'h41); send_byte(8'h41); send_byte(8'h00);
        write_length(LEN_W'(15));
        repeat (7) send_byte(8'h00);
        send_byte(8'h41);
        write_length(LEN_W'(1));
        send_byte(8'h41);
        write_length(LEN_W'(8));
        repeat (3) send_byte(8'hff);
        write_length(LEN_W'(3));
        send_byte(8'h01); send_byte(8'h02); send_byte(8'h03);
        send_byte(8'h01); send_byte(8'h02); send_byte(8'h03);

        for (int round = 0; round < 6; round++) begin
            foreach (alphabet[i]) alphabet[i] = 8'($urandom);
            write_length(LEN_W'($urandom_range(0, 15)));
            repeat (40) send_byte(pick_byte());
        end

        // fill the table with long random grams, then run past full
        write_length(LEN_W'(8));
        guard = 0;
        while (grams_stored < TABLE_ENTRIES && guard < 1100) begin
            send_byte(8'($urandom));
            guard++;
        end
        repeat (15) send_byte(8'($urandom));

        write_length(LEN_W'(1));
        repeat (20) send_byte(pick_byte());
        write_length(LEN_W'(2));
        repeat (20) send_byte(8'($urandom));

        start <= 1'b0;
        while (pending != 0) begin
            @(negedge clk);
        end
        repeat (20) @(negedge clk);
        $display("sent %0d bytes, %0d results, %0d grams stored, %0d table-full results",
                 bytes_sent, results, grams_stored, full_hits);
        if (fails == 0) begin
            $display("[ngram_frequency_counter] OK");
        end else begin
            $display("[ngram_frequency_counter] ERROR");
        end
        $finish;
    end

endmodule
